// ===== rtl/rmg_pkg.sv =====
package rmg_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FRAC_BITS_DEF    = 14;
  localparam int TAB_LEN          = 24;
  localparam int ZW               = 33;
  localparam int AW               = 14;
  localparam int ANG_SHIFT        = 18;

  localparam logic signed [16:0] DEG360 = 17'sd23040;
  localparam logic signed [16:0] DEG180 = 17'sd11520;
  localparam logic signed [16:0] DEG90  = 17'sd5760;

  localparam logic [63:0] KQ32 = 64'd2608131496;
  localparam int Q14_ONE = 16384;

  localparam logic REQ_AXIS  = 1'b0;
  localparam logic REQ_EULER = 1'b1;

  typedef struct packed {
    logic vld;
    logic typ;
  } rmg_ctl_t;

  typedef struct packed {
    logic                 neg;
    logic signed [AW-1:0] ang;
  } rmg_red_t;

  // atan(2^-i) in 2^-24 degree
  function automatic logic [31:0] atan_tab(input int idx);
    logic [31:0] v;
    case (idx)
      0:       v = 32'd754974720;
      1:       v = 32'd445687602;
      2:       v = 32'd235489088;
      3:       v = 32'd119537938;
      4:       v = 32'd60000934;
      5:       v = 32'd30029717;
      6:       v = 32'd15018523;
      7:       v = 32'd7509720;
      8:       v = 32'd3754917;
      9:       v = 32'd1877466;
      10:      v = 32'd938734;
      11:      v = 32'd469367;
      12:      v = 32'd234684;
      13:      v = 32'd117342;
      14:      v = 32'd58671;
      15:      v = 32'd29335;
      16:      v = 32'd14668;
      17:      v = 32'd7334;
      18:      v = 32'd3667;
      19:      v = 32'd1833;
      20:      v = 32'd917;
      21:      v = 32'd458;
      22:      v = 32'd229;
      23:      v = 32'd115;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/rotation_matrix_generator.sv =====
// channel   | ports                                   | handshake
// ----------+-----------------------------------------+---------------------------
// request   | in_req_type, in_angle_a..c, in_axis_x..z | start high, busy low
// result    | out_m_0_0 .. out_m_2_2                   | out_strobe, one cycle
//
// one request per cycle; the result passes through angle reduction, the CORDIC
// cell chain (steps capped at 24), the CORDIC output register and three
// multiply/sum stages
// busy is high only during reset; synchronous active-low reset clears all
// valid flags, payload is not reset; the receiver cannot stall
module rotation_matrix_generator #(
  parameter int CORDIC_STEPS = rmg_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = rmg_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_req_type,
  input  logic signed [15:0] in_angle_a,
  input  logic signed [15:0] in_angle_b,
  input  logic signed [15:0] in_angle_c,
  input  logic signed [15:0] in_axis_x,
  input  logic signed [15:0] in_axis_y,
  input  logic signed [15:0] in_axis_z,
  output logic               out_strobe,
  output logic signed [15:0] out_m_0_0,
  output logic signed [15:0] out_m_0_1,
  output logic signed [15:0] out_m_0_2,
  output logic signed [15:0] out_m_1_0,
  output logic signed [15:0] out_m_1_1,
  output logic signed [15:0] out_m_1_2,
  output logic signed [15:0] out_m_2_0,
  output logic signed [15:0] out_m_2_1,
  output logic signed [15:0] out_m_2_2
);

  localparam int W   = FRAC_BITS + 4;
  localparam int N   = (CORDIC_STEPS > rmg_pkg::TAB_LEN) ? rmg_pkg::TAB_LEN : CORDIC_STEPS;
  localparam int LAT = N + 5;
  localparam int USL = (FRAC_BITS >= 14) ? FRAC_BITS - 14 : 0;
  localparam int USR = (FRAC_BITS < 14) ? 14 - FRAC_BITS : 0;
  localparam int UHQ = (USR > 0) ? (1 << (USR - 1)) : 0;

  // wrap into [-180, 180), fold beyond 90 degrees
  function automatic rmg_pkg::rmg_red_t reduce(input logic signed [15:0] a);
    logic signed [16:0] r;
    rmg_pkg::rmg_red_t  o;
    r = 17'(a);
    if (r >= rmg_pkg::DEG360) r = r - rmg_pkg::DEG360;
    else if (r <= -rmg_pkg::DEG360) r = r + rmg_pkg::DEG360;
    if (r >= rmg_pkg::DEG180) r = r - rmg_pkg::DEG360;
    if (r < -rmg_pkg::DEG180) r = r + rmg_pkg::DEG360;
    o.neg = 1'b0;
    if (r > rmg_pkg::DEG90) begin
      r = r - rmg_pkg::DEG180;
      o.neg = 1'b1;
    end else if (r < -rmg_pkg::DEG90) begin
      r = r + rmg_pkg::DEG180;
      o.neg = 1'b1;
    end
    o.ang = r[rmg_pkg::AW-1:0];
    return o;
  endfunction

  function automatic logic signed [W-1:0] from_q14(input logic signed [15:0] v);
    logic signed [W-1:0] e;
    e = W'(v);
    return ((e + W'(UHQ)) >>> USR) <<< USL;
  endfunction

  logic acc;
  assign busy = ~rst_n;
  assign acc  = start & ~busy;

  // input stage
  rmg_pkg::rmg_red_t   red_r [3];
  rmg_pkg::rmg_ctl_t   ctl0_r;
  logic signed [W-1:0] u0_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
    end else begin
      ctl0_r.vld <= acc;
      ctl0_r.typ <= in_req_type;
    end
    red_r[0] <= reduce(in_angle_a);
    red_r[1] <= reduce(in_angle_b);
    red_r[2] <= reduce(in_angle_c);
    u0_r[0]  <= from_q14(in_axis_x);
    u0_r[1]  <= from_q14(in_axis_y);
    u0_r[2]  <= from_q14(in_axis_z);
  end

  logic signed [W-1:0] cs [3];
  logic signed [W-1:0] sn [3];

  for (genvar g = 0; g < 3; g++) begin : g_cordic
    rmg_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clk  (clk),
      .red_i(red_r[g]),
      .cos_r(cs[g]),
      .sin_r(sn[g])
    );
  end

  // side line alongside the cordic chain
  rmg_pkg::rmg_ctl_t   dly_ctl_r [N+1];
  logic signed [W-1:0] dly_u_r   [N+1][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= N; k++) begin
        dly_ctl_r[k] <= '0;
      end
    end else begin
      dly_ctl_r[0] <= ctl0_r;
      for (int k = 1; k <= N; k++) begin
        dly_ctl_r[k] <= dly_ctl_r[k-1];
      end
    end
    dly_u_r[0] <= u0_r;
    for (int k = 1; k <= N; k++) begin
      dly_u_r[k] <= dly_u_r[k-1];
    end
  end

  logic signed [15:0] m [9];

  rmg_mat #(.FRAC_BITS(FRAC_BITS)) u_mat (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (dly_ctl_r[N]),
    .cph_i   (cs[0]),
    .sph_i   (sn[0]),
    .cth_i   (cs[1]),
    .sth_i   (sn[1]),
    .cps_i   (cs[2]),
    .sps_i   (sn[2]),
    .u_i     (dly_u_r[N]),
    .strobe_r(out_strobe),
    .m_r     (m)
  );

  assign out_m_0_0 = m[0];
  assign out_m_0_1 = m[1];
  assign out_m_0_2 = m[2];
  assign out_m_1_0 = m[3];
  assign out_m_1_1 = m[4];
  assign out_m_1_2 = m[5];
  assign out_m_2_0 = m[6];
  assign out_m_2_1 = m[7];
  assign out_m_2_2 = m[8];

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe == $past(acc, LAT))
    else $error("result strobe out of step with request");

  a_range_00: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_m_0_0 <= 16'sd16384 && out_m_0_0 >= -16'sd16384))
    else $error("entry 0,0 beyond unity");

  a_range_22: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_m_2_2 <= 16'sd16384 && out_m_2_2 >= -16'sd16384))
    else $error("entry 2,2 beyond unity");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("strobe after reset");

endmodule

// ===== rtl/rmg_cordic_cell.sv =====
module rmg_cordic_cell #(
  parameter int W   = 18,
  parameter int IDX = 0
) (
  input  logic                          clk,
  input  logic signed [W-1:0]           x_i,
  input  logic signed [W-1:0]           y_i,
  input  logic signed [rmg_pkg::ZW-1:0] z_i,
  input  logic                          neg_i,
  output logic signed [W-1:0]           x_r,
  output logic signed [W-1:0]           y_r,
  output logic signed [rmg_pkg::ZW-1:0] z_r,
  output logic                          neg_r
);

  logic signed [rmg_pkg::ZW-1:0] t;
  assign t = $signed({1'b0, rmg_pkg::atan_tab(IDX)});

  always_ff @(posedge clk) begin
    neg_r <= neg_i;
    if (!z_i[rmg_pkg::ZW-1]) begin
      x_r <= x_i - (y_i >>> IDX);
      y_r <= y_i + (x_i >>> IDX);
      z_r <= z_i - t;
    end else begin
      x_r <= x_i + (y_i >>> IDX);
      y_r <= y_i - (x_i >>> IDX);
      z_r <= z_i + t;
    end
  end

endmodule

// ===== rtl/rmg_cordic.sv =====
module rmg_cordic #(
  parameter int FRAC_BITS    = rmg_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = rmg_pkg::CORDIC_STEPS_DEF
) (
  input  logic                        clk,
  input  rmg_pkg::rmg_red_t           red_i,
  output logic signed [FRAC_BITS+3:0] cos_r,
  output logic signed [FRAC_BITS+3:0] sin_r
);

  localparam int W = FRAC_BITS + 4;
  localparam int N = (CORDIC_STEPS > rmg_pkg::TAB_LEN) ? rmg_pkg::TAB_LEN : CORDIC_STEPS;
  localparam int ZW = rmg_pkg::ZW;
  localparam logic [63:0] XI64 =
    (rmg_pkg::KQ32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);

  logic signed [W-1:0]  x_w [N+1];
  logic signed [W-1:0]  y_w [N+1];
  logic signed [ZW-1:0] z_w [N+1];
  logic                 n_w [N+1];

  assign x_w[0] = W'(XI64);
  assign y_w[0] = '0;
  assign z_w[0] = $signed({{(ZW-rmg_pkg::AW-rmg_pkg::ANG_SHIFT){red_i.ang[rmg_pkg::AW-1]}},
                           red_i.ang, {rmg_pkg::ANG_SHIFT{1'b0}}});
  assign n_w[0] = red_i.neg;

  for (genvar i = 0; i < N; i++) begin : g_cell
    rmg_cordic_cell #(.W(W), .IDX(i)) u_cell (
      .clk  (clk),
      .x_i  (x_w[i]),
      .y_i  (y_w[i]),
      .z_i  (z_w[i]),
      .neg_i(n_w[i]),
      .x_r  (x_w[i+1]),
      .y_r  (y_w[i+1]),
      .z_r  (z_w[i+1]),
      .neg_r(n_w[i+1])
    );
  end

  always_ff @(posedge clk) begin
    cos_r <= n_w[N] ? -x_w[N] : x_w[N];
    sin_r <= n_w[N] ? -y_w[N] : y_w[N];
  end

endmodule

// ===== rtl/rmg_mat.sv =====
module rmg_mat #(
  parameter int FRAC_BITS = rmg_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rmg_pkg::rmg_ctl_t           ctl_i,
  input  logic signed [FRAC_BITS+3:0] cph_i,
  input  logic signed [FRAC_BITS+3:0] sph_i,
  input  logic signed [FRAC_BITS+3:0] cth_i,
  input  logic signed [FRAC_BITS+3:0] sth_i,
  input  logic signed [FRAC_BITS+3:0] cps_i,
  input  logic signed [FRAC_BITS+3:0] sps_i,
  input  logic signed [FRAC_BITS+3:0] u_i [3],
  output logic                        strobe_r,
  output logic signed [15:0]          m_r [9]
);

  localparam int W  = FRAC_BITS + 4;
  localparam int SR = (FRAC_BITS > 14) ? FRAC_BITS - 14 : 0;
  localparam int SL = (FRAC_BITS < 14) ? 14 - FRAC_BITS : 0;
  localparam int HQ = (SR > 0) ? (1 << (SR - 1)) : 0;
  localparam int QW = W + 1 + SL;
  localparam logic signed [W-1:0]   ONE  = W'(64'd1 << FRAC_BITS);
  localparam logic signed [W-1:0]   TWO  = W'(64'd2 << FRAC_BITS);
  localparam logic signed [2*W-1:0] HALF = (2*W)'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [QW-1:0]  LIM  = QW'(rmg_pkg::Q14_ONE);

  function automatic logic signed [W-1:0] sat2(input logic signed [W-1:0] v);
    logic signed [W-1:0] r;
    if (v > TWO) r = TWO;
    else if (v < -TWO) r = -TWO;
    else r = v;
    return r;
  endfunction

  function automatic logic signed [W-1:0] mul(input logic signed [W-1:0] a,
                                              input logic signed [W-1:0] b);
    logic signed [2*W-1:0] p;
    logic signed [2*W-1:0] q;
    p = sat2(a) * sat2(b);
    q = (p + HALF) >>> FRAC_BITS;
    return sat2(q[W-1:0]);
  endfunction

  function automatic logic signed [W:0] sx(input logic signed [W-1:0] v);
    return $signed({v[W-1], v});
  endfunction

  function automatic logic signed [15:0] toq(input logic signed [W:0] v);
    logic signed [QW-1:0] e;
    logic signed [QW-1:0] t;
    e = QW'(v);
    t = ((e + QW'(HQ)) >>> SR) <<< SL;
    if (t > LIM) t = LIM;
    else if (t < -LIM) t = -LIM;
    return t[15:0];
  endfunction

  // first products
  rmg_pkg::rmg_ctl_t   ctl1_r;
  logic signed [W-1:0] om_r [3];
  logic signed [W-1:0] su_r [3];
  logic signed [W-1:0] u1_r [3];
  logic signed [W-1:0] q_r  [10];
  logic signed [W-1:0] c1_r, cth1_r, cps1_r, sps1_r;
  logic signed [W-1:0] omc;

  assign omc = ONE - cph_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else begin
      ctl1_r <= ctl_i;
    end
    for (int i = 0; i < 3; i++) begin
      om_r[i] <= mul(omc, u_i[i]);
      su_r[i] <= mul(sph_i, u_i[i]);
      u1_r[i] <= u_i[i];
    end
    q_r[0] <= mul(cph_i, cps_i);
    q_r[1] <= mul(sph_i, cth_i);
    q_r[2] <= mul(cph_i, sps_i);
    q_r[3] <= mul(sph_i, sth_i);
    q_r[4] <= mul(sph_i, cps_i);
    q_r[5] <= mul(cph_i, cth_i);
    q_r[6] <= mul(sph_i, sps_i);
    q_r[7] <= mul(cph_i, sth_i);
    q_r[8] <= mul(sth_i, sps_i);
    q_r[9] <= mul(sth_i, cps_i);
    c1_r   <= cph_i;
    cth1_r <= cth_i;
    cps1_r <= cps_i;
    sps1_r <= sps_i;
  end

  // second products
  rmg_pkg::rmg_ctl_t   ctl2_r;
  logic signed [W-1:0] b_r  [9];
  logic signed [W-1:0] su2_r [3];
  logic signed [W-1:0] r_r  [4];
  logic signed [W-1:0] q2_r [10];
  logic signed [W-1:0] c2_r, cth2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else begin
      ctl2_r <= ctl1_r;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        b_r[i*3+j] <= mul(om_r[i], u1_r[j]);
      end
      su2_r[i] <= su_r[i];
    end
    r_r[0] <= mul(q_r[1], sps1_r);
    r_r[1] <= mul(q_r[1], cps1_r);
    r_r[2] <= mul(q_r[5], sps1_r);
    r_r[3] <= mul(q_r[5], cps1_r);
    for (int k = 0; k < 10; k++) begin
      q2_r[k] <= q_r[k];
    end
    c2_r   <= c1_r;
    cth2_r <= cth1_r;
  end

  // sums and output format
  logic signed [W:0] sm [9];

  always_comb begin
    if (ctl2_r.typ == rmg_pkg::REQ_AXIS) begin
      sm[0] = sx(b_r[0]) + sx(c2_r);
      sm[1] = sx(b_r[1]) - sx(su2_r[2]);
      sm[2] = sx(b_r[2]) + sx(su2_r[1]);
      sm[3] = sx(b_r[3]) + sx(su2_r[2]);
      sm[4] = sx(b_r[4]) + sx(c2_r);
      sm[5] = sx(b_r[5]) - sx(su2_r[0]);
      sm[6] = sx(b_r[6]) - sx(su2_r[1]);
      sm[7] = sx(b_r[7]) + sx(su2_r[0]);
      sm[8] = sx(b_r[8]) + sx(c2_r);
    end else begin
      sm[0] = sx(q2_r[0]) - sx(r_r[0]);
      sm[1] = sx(q2_r[4]) + sx(r_r[2]);
      sm[2] = sx(q2_r[8]);
      sm[3] = -sx(q2_r[2]) - sx(r_r[1]);
      sm[4] = -sx(q2_r[6]) + sx(r_r[3]);
      sm[5] = sx(q2_r[9]);
      sm[6] = -sx(q2_r[3]);
      sm[7] = sx(q2_r[7]);
      sm[8] = sx(cth2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= ctl2_r.vld;
    end
    for (int k = 0; k < 9; k++) begin
      m_r[k] <= toq(sm[k]);
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int STEPS = rmg_pkg::CORDIC_STEPS_DEF;
  localparam int FB    = rmg_pkg::FRAC_BITS_DEF;
  localparam int LATENCY = STEPS + 5;
  localparam int WATCHDOG = 2000;

  typedef struct {
    logic signed [15:0] m [9];
  } matrix_t;

  class matrix_scoreboard;
    matrix_t pending[$];
    int mismatches;
    int checked;

    static function longint asr(longint v, int s);
      return v >>> s;
    endfunction

    static function longint rnd(longint v, int s);
      if (s <= 0) return v;
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    static function longint clip(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    static function longint qmul(longint a, longint b);
      longint two;
      two = longint'(2) << FB;
      a = clip(a, two);
      b = clip(b, two);
      return clip(rnd(a * b, FB), two);
    endfunction

    static function longint widen(logic signed [15:0] v);
      if (FB >= 14) return longint'(v) <<< (FB - 14);
      return rnd(longint'(v), 14 - FB);
    endfunction

    static function logic signed [15:0] narrow(longint v);
      longint r;
      if (FB >= 14) r = rnd(v, FB - 14);
      else r = v <<< (14 - FB);
      return 16'(clip(r, rmg_pkg::Q14_ONE));
    endfunction

    static function void sin_cos(logic signed [15:0] ang, output longint c,
                                 output longint s);
      longint r, x, y, z, xn;
      bit flip;
      int n;
      n = STEPS > rmg_pkg::TAB_LEN ? rmg_pkg::TAB_LEN : STEPS;
      r = longint'(ang) % 23040;
      flip = 0;
      if (r >= 11520) r -= 23040;
      if (r < -11520) r += 23040;
      if (r > 5760) begin
        r -= 11520;
        flip = 1;
      end else if (r < -5760) begin
        r += 11520;
        flip = 1;
      end
      x = longint'((rmg_pkg::KQ32 + (64'd1 << (31 - FB))) >> (32 - FB));
      y = 0;
      z = r * (longint'(1) << rmg_pkg::ANG_SHIFT);
      for (int i = 0; i < n; i++) begin
        if (z >= 0) begin
          xn = x - asr(y, i);
          y = y + asr(x, i);
          z -= longint'(rmg_pkg::atan_tab(i));
        end else begin
          xn = x + asr(y, i);
          y = y - asr(x, i);
          z += longint'(rmg_pkg::atan_tab(i));
        end
        x = xn;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function void note_request(logic typ, logic signed [15:0] a, b, cc,
                               logic signed [15:0] ux, uy, uz);
      longint m [3][3];
      longint u [3];
      longint c, s, omc, cph, sph, cth, sth, cps, sps;
      matrix_t e;
      if (typ == rmg_pkg::REQ_AXIS) begin
        u[0] = widen(ux);
        u[1] = widen(uy);
        u[2] = widen(uz);
        sin_cos(a, c, s);
        omc = (longint'(1) << FB) - c;
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) m[i][j] = qmul(qmul(omc, u[i]), u[j]);
          m[i][i] += c;
        end
        m[1][0] += qmul(s, u[2]);
        m[2][0] -= qmul(s, u[1]);
        m[0][1] -= qmul(s, u[2]);
        m[2][1] += qmul(s, u[0]);
        m[0][2] += qmul(s, u[1]);
        m[1][2] -= qmul(s, u[0]);
      end else begin
        sin_cos(a, cph, sph);
        sin_cos(b, cth, sth);
        sin_cos(cc, cps, sps);
        m[0][0] = qmul(cph, cps) - qmul(qmul(sph, cth), sps);
        m[1][0] = -qmul(cph, sps) - qmul(qmul(sph, cth), cps);
        m[2][0] = -qmul(sph, sth);
        m[0][1] = qmul(sph, cps) + qmul(qmul(cph, cth), sps);
        m[1][1] = -qmul(sph, sps) + qmul(qmul(cph, cth), cps);
        m[2][1] = qmul(cph, sth);
        m[0][2] = qmul(sth, sps);
        m[1][2] = qmul(sth, cps);
        m[2][2] = cth;
      end
      for (int k = 0; k < 9; k++) e.m[k] = narrow(m[k / 3][k % 3]);
      pending.push_back(e);
    endfunction

    function void check_result(matrix_t got);
      matrix_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result matrix");
        return;
      end
      e = pending.pop_front();
      checked++;
      for (int k = 0; k < 9; k++) begin
        if (got.m[k] !== e.m[k]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("m_%0d_%0d: expected %0d, got %0d", k / 3, k % 3,
                     e.m[k], got.m[k]);
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic in_req_type = 0;
  logic signed [15:0] in_angle_a = 0, in_angle_b = 0, in_angle_c = 0;
  logic signed [15:0] in_axis_x = 0, in_axis_y = 0, in_axis_z = 0;
  logic out_strobe;
  logic signed [15:0] out_m_0_0, out_m_0_1, out_m_0_2, out_m_1_0, out_m_1_1;
  logic signed [15:0] out_m_1_2, out_m_2_0, out_m_2_1, out_m_2_2;

  matrix_scoreboard sb = new();
  int idle_pct = 0;
  int n_axis = 0, n_euler = 0;
  int quiet = 0;

  always #4 clk = ~clk;

  rotation_matrix_generator u_top (.*);

  always @(posedge clk) begin
    matrix_t got;
    if (rst_n && out_strobe) begin
      got.m = '{out_m_0_0, out_m_0_1, out_m_0_2, out_m_1_0, out_m_1_1,
                out_m_1_2, out_m_2_0, out_m_2_1, out_m_2_2};
      sb.check_result(got);
    end
    if (rst_n && start && !busy) begin
      sb.note_request(in_req_type, in_angle_a, in_angle_b, in_angle_c,
                      in_axis_x, in_axis_y, in_axis_z);
      if (in_req_type == rmg_pkg::REQ_AXIS) n_axis++;
      else n_euler++;
    end
    if ((rst_n && start && !busy) || (rst_n && out_strobe)) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG) begin
      $display("watchdog expired");
      $display("** rotation_matrix_generator: FAILED **");
      $finish;
    end
  end

  task automatic send_request(logic typ, logic signed [15:0] a, b, c, x, y, z);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(negedge clk);
    start = 1;
    in_req_type = typ;
    in_angle_a = a;
    in_angle_b = b;
    in_angle_c = c;
    in_axis_x = x;
    in_axis_y = y;
    in_axis_z = z;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start = 0;
  endtask

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(3))
      0: return 16'($signed($urandom_range(46080)) - 23040);
      1: return 16'($signed($urandom_range(11520)) - 5760);
      2: return 16'($urandom);
      default: return 16'(5760 * ($signed($urandom_range(8)) - 4)
                          + $signed($urandom_range(2)) - 1);
    endcase
  endfunction

  function automatic logic signed [15:0] rand_comp();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  task automatic random_request();
    send_request($urandom_range(1), rand_angle(), rand_angle(), rand_angle(),
                 rand_comp(), rand_comp(), rand_comp());
  endtask

  initial begin
    logic signed [15:0] edge_angs [10];
    edge_angs = '{16'sd0, 16'sd5760, -16'sd5760, 16'sd5761, -16'sd5761,
                  16'sd11520, -16'sd11520, 16'sd23040, -16'sd23040, 16'sh7fff};
    repeat (8) @(negedge clk);
    rst_n = 1;

    // directed: wrap and fold boundaries, unit axes, off-range axes
    for (int k = 0; k < 10; k++)
      send_request(rmg_pkg::REQ_AXIS, edge_angs[k], 16'sh7fff, 16'sh8000, 16'sd16384,
                   16'sd0, 16'sd0);
    send_request(rmg_pkg::REQ_AXIS, 16'sd2880, 0, 0, 0, -16'sd16384, 0);
    send_request(rmg_pkg::REQ_AXIS, 16'sd1920, 0, 0, 16'sd9459, 16'sd9459, 16'sd9459);
    send_request(rmg_pkg::REQ_AXIS, 16'sh8000, 0, 0, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_request(rmg_pkg::REQ_AXIS, -16'sd3000, 0, 0, 16'shffff, 16'sh5555, 16'shaaaa);
    for (int k = 0; k < 8; k++)
      send_request(rmg_pkg::REQ_EULER, edge_angs[k], edge_angs[9 - k],
                   edge_angs[(k + 3) % 10], 16'sh7fff, 16'sh8000, 16'shffff);
    send_request(rmg_pkg::REQ_EULER, 16'sh8000, 16'sh7fff, 16'sh8000, 0, 0, 0);

    // sender pauses until all results are in
    while (sb.pending.size() != 0) @(negedge clk);

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 77 : (phase == 3 ? 15 : 0);
      repeat (260) random_request();
      if (phase == 1) while (sb.pending.size() != 0) @(negedge clk);
    end
    idle_pct = 0;

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    $display("covered %0d axis-angle and %0d euler requests, %0d matrices checked",
             n_axis, n_euler, sb.checked);
    $display("angle wrap and fold edges, saturating axes, idle phases 0/77/15 pct");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("** rotation_matrix_generator: PASSED **");
    end else begin
      $display("%0d mismatches, %0d outstanding", sb.mismatches, sb.pending.size());
      $display("** rotation_matrix_generator: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rmg_pkg.sv
rtl/rmg_cordic_cell.sv
rtl/rmg_cordic.sv
rtl/rmg_mat.sv
rtl/rotation_matrix_generator.sv
tb/testbench.sv
